// ----- hdl/wsu_pkg.sv -----
package wsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_DROP  = 2'd2,
        KIND_BIG   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEAD    = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [7:0] HEAD_TEXT   = 8'h81;
    localparam logic [7:0] HEAD_BINARY = 8'h82;
    localparam logic [6:0] LEN7_MAX    = 7'd125;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] EXT_LOW_BYTES = 4'd4;
    localparam logic [31:0] MASK_BYTES = 32'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        kind_t      kind;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

// ----- hdl/wsu_stream_if.sv -----
interface wsu_stream_if #(
    parameter type item_t = logic [7:0]
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/wsu_in_stage.sv -----
module wsu_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    wsu_stream_if.sink           rx,
    input  logic                 advance,
    output logic                 byte_valid,
    output logic [7:0]           byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.data.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;
endmodule

// ----- hdl/wsu_parser.sv -----
module wsu_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        b,
    output wsu_pkg::result_t  res
);
    wsu_pkg::phase_t phase_reg, phase_next;
    logic            head_ok_reg, head_ok_next;
    logic [3:0]      ext_reg, ext_next;
    logic [31:0]     len_reg, len_next;
    logic [31:0]     key_reg, key_next;
    logic [31:0]     idx_reg, idx_next;
    logic            upper_reg, upper_next;

    logic [6:0]      len7;
    logic [3:0]      ext_dec;
    logic            upper_hit;
    logic [31:0]     idx_inc;
    logic [7:0]      key_byte;

    assign len7      = b[6:0];
    assign ext_dec   = (ext_reg != 4'd0) ? ext_reg - 4'd1 : 4'd0;
    assign upper_hit = upper_reg || ((ext_reg > wsu_pkg::EXT_LOW_BYTES) && (b != 8'd0));
    assign idx_inc   = idx_reg + 32'd1;

    always_comb
    begin
        unique case (idx_reg[1:0])
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        head_ok_next = head_ok_reg;
        ext_next     = ext_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        upper_next   = upper_reg;
        res          = '0;
        unique case (phase_reg)
            wsu_pkg::PH_LEN:
            begin
                upper_next = 1'b0;
                if (len7 <= wsu_pkg::LEN7_MAX)
                begin
                    len_next   = {25'd0, len7};
                    ext_next   = 4'd0;
                    key_next   = '0;
                    idx_next   = '0;
                    phase_next = wsu_pkg::PH_MASK;
                end
                else
                begin
                    len_next   = '0;
                    ext_next   = (len7 == wsu_pkg::LEN7_EXT16) ? wsu_pkg::EXT16_BYTES
                                                               : wsu_pkg::EXT64_BYTES;
                    phase_next = wsu_pkg::PH_EXT;
                end
            end
            wsu_pkg::PH_EXT:
            begin
                if (ext_reg > wsu_pkg::EXT_LOW_BYTES)
                begin
                    upper_next = upper_hit;
                end
                else
                begin
                    len_next = {len_reg[23:0], b};
                end
                ext_next = ext_dec;
                if (ext_dec == 4'd0)
                begin
                    if (upper_hit)
                    begin
                        upper_next     = 1'b0;
                        phase_next     = wsu_pkg::PH_HEAD;
                        res.valid      = 1'b1;
                        res.item.kind  = wsu_pkg::KIND_BIG;
                        res.item.last  = 1'b1;
                    end
                    else
                    begin
                        key_next   = '0;
                        idx_next   = '0;
                        phase_next = wsu_pkg::PH_MASK;
                    end
                end
            end
            wsu_pkg::PH_MASK:
            begin
                key_next = {key_reg[23:0], b};
                idx_next = idx_inc;
                if (idx_inc >= wsu_pkg::MASK_BYTES)
                begin
                    idx_next = '0;
                    if (len_reg == 32'd0)
                    begin
                        phase_next    = wsu_pkg::PH_HEAD;
                        res.valid     = 1'b1;
                        res.item.kind = head_ok_reg ? wsu_pkg::KIND_EMPTY
                                                    : wsu_pkg::KIND_DROP;
                        res.item.last = 1'b1;
                    end
                    else
                    begin
                        phase_next = wsu_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsu_pkg::PH_PAYLOAD:
            begin
                idx_next = idx_inc;
                if (idx_inc == len_reg)
                begin
                    phase_next = wsu_pkg::PH_HEAD;
                end
                if (head_ok_reg)
                begin
                    res.valid          = 1'b1;
                    res.item.data_byte = b ^ key_byte;
                    res.item.kind      = wsu_pkg::KIND_DATA;
                    res.item.last      = (idx_inc == len_reg);
                end
                else if (idx_inc == len_reg)
                begin
                    res.valid     = 1'b1;
                    res.item.kind = wsu_pkg::KIND_DROP;
                    res.item.last = 1'b1;
                end
            end
            default:
            begin
                head_ok_next = (b == wsu_pkg::HEAD_TEXT) || (b == wsu_pkg::HEAD_BINARY);
                phase_next   = wsu_pkg::PH_LEN;
            end
        endcase
        if (!step)
        begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= wsu_pkg::PH_HEAD;
            head_ok_reg <= 1'b0;
            ext_reg     <= '0;
            len_reg     <= '0;
            key_reg     <= '0;
            idx_reg     <= '0;
            upper_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            head_ok_reg <= head_ok_next;
            ext_reg     <= ext_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            idx_reg     <= idx_next;
            upper_reg   <= upper_next;
        end
    end
endmodule

// ----- hdl/wsu_out_stage.sv -----
module wsu_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  wsu_pkg::result_t  res,
    output logic              slot_free,
    wsu_stream_if.source      tx
);
    logic               valid_reg;
    logic               valid_next;
    wsu_pkg::out_item_t item_reg;

    assign slot_free = !valid_reg || tx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            item_reg <= res.item;
        end
    end

    assign tx.valid = valid_reg;
    assign tx.data  = item_reg;
endmodule

// ----- hdl/websocket_frame_unmasker.sv -----
// channel  dir  payload                         item
// rx       in   rx_byte[7:0]                    one stream byte
// tx       out  data_byte[7:0], kind[1:0], last  payload byte or marker
//
// One byte per clock sustained while tx is ready; an accepted rx byte passes the input register,
// then the frame state machine feeding the result register that drives tx valid.
// rst_n is asynchronous, active low; afterwards the parser waits for a header byte.
// A stalled tx holds its item; rx keeps taking a byte while the input register is free.
module websocket_frame_unmasker (
    input  logic         clk,
    input  logic         rst_n,
    wsu_stream_if.sink   rx,
    wsu_stream_if.source tx
);
    logic             in_valid;
    logic [7:0]       in_byte;
    logic             out_free;
    logic             advance;
    wsu_pkg::result_t res;

    assign advance = in_valid && out_free;

    wsu_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (in_valid),
        .byte_data  (in_byte)
    );

    wsu_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .b     (in_byte),
        .res   (res)
    );

    wsu_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .slot_free (out_free),
        .tx        (tx)
    );

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && (tx.data.kind != wsu_pkg::KIND_DATA) |-> tx.data.last)
        else $error("marker item without last");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && (tx.data.kind != wsu_pkg::KIND_DATA) |-> (tx.data.data_byte == 8'd0))
        else $error("marker item with nonzero data");

    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready |=> in_valid)
        else $error("accepted byte not held in input register");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result produced with output register occupied");
endmodule

// ----- test/websocket_frame_unmasker_chk.sv -----
module websocket_frame_unmasker_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               tx_valid,
    input  logic               tx_ready,
    input  wsu_pkg::out_item_t tx_item,
    output int                 errors,
    output int                 pending,
    output int                 checked
);
    timeunit 1ns;
    timeprecision 1ps;

    wsu_pkg::phase_t parse_phase;
    logic        head_ok;
    logic [3:0]  ext_left;
    logic [31:0] frame_len;
    logic [31:0] key_word;
    logic [31:0] key_pos;
    logic        upper_seen;

    wsu_pkg::out_item_t decoded_q [$];

    task automatic decode_byte(input logic [7:0] b);
        wsu_pkg::out_item_t r;
        logic       emit;
        logic [7:0] key;
        logic       done;
        emit = 1'b0;
        r = '{data_byte: 8'd0, kind: wsu_pkg::KIND_DATA, last: 1'b0};
        case (parse_phase)
            wsu_pkg::PH_LEN:
            begin
                upper_seen = 1'b0;
                frame_len = '0;
                if (b[6:0] <= wsu_pkg::LEN7_MAX)
                begin
                    frame_len = {25'd0, b[6:0]};
                    ext_left = '0;
                    key_word = '0;
                    key_pos = '0;
                    parse_phase = wsu_pkg::PH_MASK;
                end
                else
                begin
                    ext_left = (b[6:0] == wsu_pkg::LEN7_EXT16) ? wsu_pkg::EXT16_BYTES
                                                               : wsu_pkg::EXT64_BYTES;
                    parse_phase = wsu_pkg::PH_EXT;
                end
            end
            wsu_pkg::PH_EXT:
            begin
                if (ext_left > wsu_pkg::EXT_LOW_BYTES)
                begin
                    if (b != 8'd0)
                        upper_seen = 1'b1;
                end
                else
                    frame_len = {frame_len[23:0], b};
                if (ext_left != 4'd0)
                    ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0)
                begin
                    if (upper_seen)
                    begin
                        upper_seen = 1'b0;
                        parse_phase = wsu_pkg::PH_HEAD;
                        emit = 1'b1;
                        r.kind = wsu_pkg::KIND_BIG;
                        r.last = 1'b1;
                    end
                    else
                    begin
                        key_word = '0;
                        key_pos = '0;
                        parse_phase = wsu_pkg::PH_MASK;
                    end
                end
            end
            wsu_pkg::PH_MASK:
            begin
                key_word = {key_word[23:0], b};
                key_pos = key_pos + 32'd1;
                if (key_pos >= wsu_pkg::MASK_BYTES)
                begin
                    key_pos = '0;
                    if (frame_len == 32'd0)
                    begin
                        parse_phase = wsu_pkg::PH_HEAD;
                        emit = 1'b1;
                        r.kind = head_ok ? wsu_pkg::KIND_EMPTY : wsu_pkg::KIND_DROP;
                        r.last = 1'b1;
                    end
                    else
                        parse_phase = wsu_pkg::PH_PAYLOAD;
                end
            end
            wsu_pkg::PH_PAYLOAD:
            begin
                key = key_word[8 * (3 - key_pos[1:0]) +: 8];
                key_pos = key_pos + 32'd1;
                done = (key_pos == frame_len);
                if (done)
                    parse_phase = wsu_pkg::PH_HEAD;
                if (head_ok)
                begin
                    emit = 1'b1;
                    r.data_byte = b ^ key;
                    r.last = done;
                end
                else if (done)
                begin
                    emit = 1'b1;
                    r.kind = wsu_pkg::KIND_DROP;
                    r.last = 1'b1;
                end
            end
            default:
            begin
                head_ok = (b == wsu_pkg::HEAD_TEXT) || (b == wsu_pkg::HEAD_BINARY);
                parse_phase = wsu_pkg::PH_LEN;
            end
        endcase
        if (emit)
            decoded_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        wsu_pkg::out_item_t want;
        if (!rst_n)
        begin
            parse_phase = wsu_pkg::PH_HEAD;
            head_ok = 1'b0;
            ext_left = '0;
            frame_len = '0;
            key_word = '0;
            key_pos = '0;
            upper_seen = 1'b0;
            decoded_q.delete();
            errors <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (tx_valid && tx_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("%0t: unexpected item: data %h kind %0d last %b",
                                 $time, tx_item.data_byte, tx_item.kind, tx_item.last);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    checked <= checked + 1;
                    if (tx_item.data_byte !== want.data_byte || tx_item.kind !== want.kind
                        || tx_item.last !== want.last)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display({"%0t: mismatch: expected data %h kind %0d last %b, ",
                                      "got data %h kind %0d last %b"},
                                     $time, want.data_byte, want.kind, want.last,
                                     tx_item.data_byte, tx_item.kind, tx_item.last);
                    end
                end
            end
            if (rx_valid && rx_ready)
                decode_byte(rx_byte);
            pending <= decoded_q.size();
        end
    end

endmodule

// ----- test/websocket_frame_unmasker_tb.sv -----
module websocket_frame_unmasker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime    HALF_PERIOD = 6ns;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;
    localparam int         STREAM_BYTES = 820;
    localparam int         QUIET_FROM   = 680;
    localparam int         DRAIN_CYCLES = 8;

    typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    logic clk = 1'b0;
    logic rst_n;
    logic gaps_on;

    int errors;
    int pending;
    int checked;
    int byte_count;
    int frame_count;
    int reject_count;
    int oversize_count;

    wsu_stream_if #(.item_t(wsu_pkg::in_item_t))  rx ();
    wsu_stream_if #(.item_t(wsu_pkg::out_item_t)) tx ();

    websocket_frame_unmasker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx)
    );

    websocket_frame_unmasker_chk u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .rx_byte  (rx.data.rx_byte),
        .tx_valid (tx.valid),
        .tx_ready (tx.ready),
        .tx_item  (tx.data),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    always #(HALF_PERIOD) clk = ~clk;

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        rx.valid <= 1'b1;
        rx.data <= wsu_pkg::in_item_t'(b);
        @(posedge clk);
        while (!rx.ready) @(posedge clk);
        byte_count++;
    endtask

    task automatic send_frame(input logic [7:0] head, input len_form_t form,
                              input logic [31:0] len, input logic big, input logic [31:0] mask);
        logic ignored_bit;
        int   hot;
        ignored_bit = 1'($urandom_range(0, 1));
        frame_count++;
        if (head != wsu_pkg::HEAD_TEXT && head != wsu_pkg::HEAD_BINARY)
            reject_count++;
        send_byte(head);
        case (form)
            LEN_SHORT: send_byte({ignored_bit, len[6:0]});
            LEN_EXT16:
            begin
                send_byte({ignored_bit, wsu_pkg::LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({ignored_bit, LEN7_EXT64});
                hot = $urandom_range(0, 3);
                for (int i = 0; i < 4; i++)
                begin
                    if (!big)
                        send_byte(8'd0);
                    else if (i == hot)
                        send_byte(8'($urandom_range(1, 255)));
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
                for (int i = 3; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        if (big)
            oversize_count++;
        else
        begin
            for (int i = 3; i >= 0; i--)
                send_byte(mask[8 * i +: 8]);
            for (int i = 0; i < int'(len); i++)
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // output side: random stall bursts while gaps_on
    initial
    begin
        tx.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                tx.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            tx.ready <= 1'b1;
        end
    end

    initial
    begin
        int          pick;
        logic [7:0]  head;
        logic [31:0] mask;
        logic [31:0] len;

        byte_count = 0;
        frame_count = 0;
        reject_count = 0;
        oversize_count = 0;
        gaps_on = 1'b0;
        rst_n <= 1'b0;
        rx.valid <= 1'b0;
        rx.data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty text frame, rejected empty frame, oversized 64-bit length,
        // one-byte frame under an all-ones key
        send_frame(wsu_pkg::HEAD_TEXT, LEN_SHORT, 32'd0, 1'b0, 32'h11223344);
        send_frame(8'h7F, LEN_SHORT, 32'd0, 1'b0, 32'h00000000);
        send_frame(wsu_pkg::HEAD_BINARY, LEN_EXT64, 32'd5, 1'b1, 32'h0);
        send_frame(wsu_pkg::HEAD_TEXT, LEN_SHORT, 32'd1, 1'b0, 32'hFFFFFFFF);

        while (byte_count < STREAM_BYTES)
        begin
            gaps_on = (byte_count < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            head = ($urandom_range(0, 1) == 0) ? wsu_pkg::HEAD_TEXT : wsu_pkg::HEAD_BINARY;
            case ($urandom_range(0, 9))
                0: mask = 32'h0;
                1: mask = 32'hFFFFFFFF;
                default: mask = $urandom;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
                send_frame(head, LEN_SHORT, len, 1'b0, mask);
            end
            else if (pick < 62)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 400)
                                                  : $urandom_range(0, 20);
                send_frame(head, LEN_EXT16, len, 1'b0, mask);
            end
            else if (pick < 70)
                send_frame(head, LEN_EXT64, $urandom_range(0, 16), 1'b0, mask);
            else if (pick < 80)
            begin
                if ($urandom_range(0, 2) == 0)
                    head = 8'($urandom_range(0, 255));
                send_frame(head, LEN_EXT64, $urandom, 1'b1, mask);
            end
            else
            begin
                do
                    head = 8'($urandom_range(0, 255));
                while (head == wsu_pkg::HEAD_TEXT || head == wsu_pkg::HEAD_BINARY);
                if ($urandom_range(0, 3) == 0)
                    send_frame(head, LEN_EXT16, $urandom_range(0, 20), 1'b0, mask);
                else
                    send_frame(head, LEN_SHORT, $urandom_range(0, 12), 1'b0, mask);
            end
        end
        gaps_on = 1'b0;
        rx.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d bytes in %0d frames: %0d with a rejected head, %0d oversized.",
                 byte_count, frame_count, reject_count, oversize_count);
        $display("Compared %0d unmasked bytes and markers, %0d errors.", checked, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
